### rtl/d2q9_bgk_collide_bounce_back_unit_defines.svh
// assertion helpers used by the checker file
`ifndef D2Q9_BGK_COLLIDE_BOUNCE_BACK_UNIT_DEFINES_SVH
`define D2Q9_BGK_COLLIDE_BOUNCE_BACK_UNIT_DEFINES_SVH

// property checked only outside reset
`define D2Q9_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define D2Q9_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/d2q9_pkg.sv
`timescale 1ns / 1ps
package d2q9_pkg;

    localparam int NUM_DIR     = 9;
    localparam int POP_W       = 32;
    localparam int NUM_OUT     = 12;
    localparam int IN_W        = NUM_DIR * POP_W;
    localparam int OUT_W       = NUM_OUT * POP_W;
    localparam int CFG_AW      = 2;
    localparam int CFG_DW      = 30;
    localparam int RATE_W      = 30;
    localparam int FORCE_W     = 26;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [RATE_W-1:0]         RATE_RST  = 30'd268435456;
    localparam logic signed [FORCE_W-1:0] FORCE_RST = 26'sd26844;
    localparam logic                      SAVE_RST  = 1'b1;

    typedef logic [NUM_DIR-1:0][POP_W-1:0] t_pops;

    typedef struct packed {
        t_pops              pops;
        logic               obstacle;
        logic signed [31:0] rho;
        logic signed [34:0] jx;
        logic signed [34:0] jy;
    } t_node;

    typedef struct packed {
        logic [RATE_W-1:0]         rate;
        logic signed [FORCE_W-1:0] force_x;
        logic                      save;
    } t_cfg;

    typedef enum logic [CFG_AW-1:0] {
        REG_RATE    = 2'd0,
        REG_FORCE_X = 2'd1,
        REG_SAVE    = 2'd2
    } t_reg_idx;

    typedef logic [3:0] t_dir;

    // direction that bounces back into each slot
    localparam t_dir OPPOSITE [NUM_DIR] = '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2,
                                            4'd7, 4'd8, 4'd5, 4'd6};

    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        if (x > 40'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -40'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage

### rtl/d2q9_front.sv
`timescale 1ns / 1ps
module d2q9_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [d2q9_pkg::IN_W-1:0] s_axis_tdata,
    input  logic                      s_axis_tuser,
    output d2q9_pkg::t_node           o_node,
    output logic                      o_node_valid,
    input  logic                      i_node_ready
);
    import d2q9_pkg::*;

    logic               r_valid;
    t_node              r_node;
    t_node              n_node;
    logic signed [39:0] f [NUM_DIR];
    logic signed [39:0] sum;
    logic signed [39:0] jx;
    logic signed [39:0] jy;

    always_comb begin
        for (int i = 0; i < NUM_DIR; i++) begin
            f[i] = 40'($signed(s_axis_tdata[i*POP_W +: POP_W]));
        end
        sum = '0;
        for (int i = 0; i < NUM_DIR; i++) begin
            sum = sum + f[i];
        end
        jx = f[1] + f[5] + f[8] - f[3] - f[6] - f[7];
        jy = f[2] + f[5] + f[6] - f[4] - f[7] - f[8];
        n_node.pops     = s_axis_tdata;
        n_node.obstacle = s_axis_tuser;
        n_node.rho      = sat32(sum);
        n_node.jx       = jx[34:0];
        n_node.jy       = jy[34:0];
    end

    assign s_axis_tready = !r_valid || i_node_ready;
    assign o_node_valid  = r_valid;
    assign o_node        = r_node;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_node <= n_node;
        end
    end

endmodule

### rtl/d2q9_queue.sv
`timescale 1ns / 1ps
module d2q9_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  d2q9_pkg::t_node i_node,
    output logic            o_valid,
    input  logic            i_ready,
    output d2q9_pkg::t_node o_node
);
    import d2q9_pkg::*;

    t_node               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                push;
    logic                pop;

    assign o_ready = r_count != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_node  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_node;
        end
    end

endmodule

### rtl/d2q9_back.sv
`timescale 1ns / 1ps
module d2q9_back #(
    parameter int FRACTION_BITS = 28
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  d2q9_pkg::t_cfg             i_cfg,
    input  d2q9_pkg::t_node            i_node,
    input  logic                       i_node_valid,
    output logic                       o_node_ready,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [d2q9_pkg::OUT_W-1:0] m_axis_tdata
);
    import d2q9_pkg::*;

    localparam int FB        = FRACTION_BITS;
    localparam int NW        = 35 + FB;
    localparam int DIV_STEPS = 32;
    localparam int NSTAGE    = 1 + DIV_STEPS + 12;

    localparam longint W4_9_RAW  = ((longint'(4) <<< FB) * 2 + 9) / 18;
    localparam longint W1_9_RAW  = ((longint'(1) <<< FB) * 2 + 9) / 18;
    localparam longint W1_36_RAW = ((longint'(1) <<< FB) * 2 + 36) / 72;
    localparam logic signed [31:0] W4_9  = (W4_9_RAW > 64'sd2147483647) ?
                                           32'sh7fffffff : W4_9_RAW[31:0];
    localparam logic signed [31:0] W1_9  = (W1_9_RAW > 64'sd2147483647) ?
                                           32'sh7fffffff : W1_9_RAW[31:0];
    localparam logic signed [31:0] W1_36 = (W1_36_RAW > 64'sd2147483647) ?
                                           32'sh7fffffff : W1_36_RAW[31:0];

    typedef struct packed {
        t_pops              pops;
        logic               obst;
        logic               rho_pos;
        logic signed [31:0] rho;
        logic [30:0]        d;
        logic               negx;
        logic               negy;
        logic               ovfx;
        logic               ovfy;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic [31:0]        qx;
        logic [31:0]        qy;
        logic [31:0]        lx;
        logic [31:0]        ly;
    } t_div;

    typedef struct packed {
        t_pops              pops;
        logic               obst;
        logic signed [31:0] rho;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
    } t_carry;

    // fixed point multiply: round half away from zero, then saturate
    function automatic logic signed [31:0] mq(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] r;
        m = p[63] ? 64'(-p) : 64'(p);
        r = (m + (64'd1 << (FB - 1))) >> FB;
        if (!p[63]) begin
            return (r > 64'd2147483647) ? 32'sh7fffffff : r[31:0];
        end else begin
            return (r > 64'd2147483648) ? 32'sh80000000 : 32'(-r);
        end
    endfunction

    function automatic t_div div_step(input t_div s);
        t_div        o;
        logic [31:0] tx;
        logic [31:0] ty;
        o  = s;
        tx = {s.rx[30:0], s.lx[31]};
        ty = {s.ry[30:0], s.ly[31]};
        if (tx >= {1'b0, s.d}) begin
            o.rx = tx - {1'b0, s.d};
            o.qx = {s.qx[30:0], 1'b1};
        end else begin
            o.rx = tx;
            o.qx = {s.qx[30:0], 1'b0};
        end
        if (ty >= {1'b0, s.d}) begin
            o.ry = ty - {1'b0, s.d};
            o.qy = {s.qy[30:0], 1'b1};
        end else begin
            o.ry = ty;
            o.qy = {s.qy[30:0], 1'b0};
        end
        o.lx = {s.lx[30:0], 1'b0};
        o.ly = {s.ly[30:0], 1'b0};
        return o;
    endfunction

    // quotient magnitude is clamped to 2^31 before the sign goes back on
    function automatic logic signed [31:0] quot(input logic [31:0] q, input logic ovf,
                                                input logic neg);
        logic [32:0]        m;
        logic signed [39:0] v;
        m = (ovf || q > 32'h80000000) ? 33'h080000000 : {1'b0, q};
        v = 40'(m);
        if (neg) v = -v;
        return sat32(v);
    endfunction

    logic               en;
    logic               r_valid [NSTAGE];
    t_div               r_div [DIV_STEPS+1];
    t_div               n_div0;
    logic [34:0]        magx;
    logic [34:0]        magy;
    logic [NW-1:0]      nx;
    logic [NW-1:0]      ny;
    logic [63:0]        hx;
    logic [63:0]        hy;

    t_carry             r_a;
    t_carry             r_b;
    logic signed [63:0] r_b_pxx;
    logic signed [63:0] r_b_pyy;
    t_carry             r_c;
    logic signed [31:0] r_c_usq;
    logic signed [31:0] r_c_tux;
    logic signed [31:0] r_c_tuy;
    t_carry             r_d;
    logic signed [34:0] r_d_base;
    logic signed [32:0] r_d_cv [NUM_DIR];
    t_carry             r_e;
    logic signed [34:0] r_e_base;
    logic signed [32:0] r_e_cv [NUM_DIR];
    logic signed [63:0] r_e_csq [NUM_DIR];
    t_carry             r_f;
    logic signed [31:0] r_f_poly [NUM_DIR];
    t_carry             r_g;
    logic signed [63:0] r_g_rp [NUM_DIR];
    t_carry             r_h;
    logic signed [31:0] r_h_t [NUM_DIR];
    t_carry             r_i;
    logic signed [63:0] r_i_wt [NUM_DIR];
    t_carry             r_j;
    logic signed [31:0] r_j_dd [NUM_DIR];
    t_carry             r_k;
    logic signed [63:0] r_k_rd [NUM_DIR];
    logic [OUT_W-1:0]   r_out;

    logic signed [31:0] weight [NUM_DIR];
    logic signed [30:0] rate_s;

    always_comb begin
        weight[0] = W4_9;
        for (int i = 1; i < 5; i++) weight[i] = W1_9;
        for (int i = 5; i < NUM_DIR; i++) weight[i] = W1_36;
    end

    assign rate_s        = $signed({1'b0, i_cfg.rate});
    assign en            = !r_valid[NSTAGE-1] || m_axis_tready;
    assign o_node_ready  = en;
    assign m_axis_tvalid = r_valid[NSTAGE-1];
    assign m_axis_tdata  = r_out;

    // divider set-up: dividend is |j| shifted up by the fraction width
    always_comb begin
        magx = i_node.jx[34] ? 35'(-i_node.jx) : 35'(i_node.jx);
        magy = i_node.jy[34] ? 35'(-i_node.jy) : 35'(i_node.jy);
        nx   = NW'(magx) << FB;
        ny   = NW'(magy) << FB;
        hx   = 64'(nx >> 32);
        hy   = 64'(ny >> 32);
        n_div0.pops    = i_node.pops;
        n_div0.obst    = i_node.obstacle;
        n_div0.rho     = i_node.rho;
        n_div0.rho_pos = !i_node.rho[31] && (i_node.rho != '0);
        n_div0.d       = i_node.rho[30:0];
        n_div0.negx    = i_node.jx[34];
        n_div0.negy    = i_node.jy[34];
        n_div0.ovfx    = hx >= 64'(i_node.rho[30:0]);
        n_div0.ovfy    = hy >= 64'(i_node.rho[30:0]);
        n_div0.rx      = hx[31:0];
        n_div0.ry      = hy[31:0];
        n_div0.qx      = '0;
        n_div0.qy      = '0;
        n_div0.lx      = nx[31:0];
        n_div0.ly      = ny[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTAGE; k++) r_valid[k] <= 1'b0;
        end else if (en) begin
            r_valid[0] <= i_node_valid;
            for (int k = 1; k < NSTAGE; k++) r_valid[k] <= r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_div[0] <= n_div0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_div[k+1] <= div_step(r_div[k]);
            end
        end
    end

    // velocity, force, the equilibrium chain and the output with bounce-back
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a.pops <= r_div[DIV_STEPS].pops;
            r_a.obst <= r_div[DIV_STEPS].obst;
            r_a.rho  <= r_div[DIV_STEPS].rho;
            if (r_div[DIV_STEPS].rho_pos) begin
                r_a.ux <= sat32(40'(quot(r_div[DIV_STEPS].qx, r_div[DIV_STEPS].ovfx,
                                         r_div[DIV_STEPS].negx)) + 40'(i_cfg.force_x));
                r_a.uy <= quot(r_div[DIV_STEPS].qy, r_div[DIV_STEPS].ovfy,
                               r_div[DIV_STEPS].negy);
            end else begin
                r_a.ux <= '0;
                r_a.uy <= '0;
            end

            r_b     <= r_a;
            r_b_pxx <= r_a.ux * r_a.ux;
            r_b_pyy <= r_a.uy * r_a.uy;

            r_c     <= r_b;
            r_c_usq <= sat32(40'(mq(r_b_pxx)) + 40'(mq(r_b_pyy)));
            r_c_tux <= sat32(40'(r_b.ux) * 40'sd3);
            r_c_tuy <= sat32(40'(r_b.uy) * 40'sd3);

            r_d       <= r_c;
            r_d_base  <= -$signed({2'b00, 33'((35'(r_c_usq) * 35'd3) >> 1)});
            r_d_cv[0] <= '0;
            r_d_cv[1] <= 33'(r_c_tux);
            r_d_cv[2] <= 33'(r_c_tuy);
            r_d_cv[3] <= -33'(r_c_tux);
            r_d_cv[4] <= -33'(r_c_tuy);
            r_d_cv[5] <= 33'(sat32(40'(r_c_tux) + 40'(r_c_tuy)));
            r_d_cv[6] <= 33'(sat32(40'(r_c_tuy) - 40'(r_c_tux)));
            r_d_cv[7] <= 33'(sat32(-(40'(r_c_tux) + 40'(r_c_tuy))));
            r_d_cv[8] <= 33'(sat32(40'(r_c_tux) - 40'(r_c_tuy)));

            r_e      <= r_d;
            r_e_base <= r_d_base;
            r_f      <= r_e;
            r_g      <= r_f;
            r_h      <= r_g;
            r_i      <= r_h;
            r_j      <= r_i;
            r_k      <= r_j;
            for (int i = 0; i < NUM_DIR; i++) begin
                r_e_cv[i]   <= r_d_cv[i];
                r_e_csq[i]  <= r_d_cv[i] * r_d_cv[i];
                r_f_poly[i] <= sat32(40'(r_e_base) + 40'(r_e_cv[i])
                                     + 40'(mq(r_e_csq[i]) >>> 1));
                r_g_rp[i]   <= r_f.rho * r_f_poly[i];
                r_h_t[i]    <= sat32(40'(r_g.rho) + 40'(mq(r_g_rp[i])));
                r_i_wt[i]   <= weight[i] * r_h_t[i];
                r_j_dd[i]   <= sat32(40'(mq(r_i_wt[i]))
                                     - 40'($signed(r_i.pops[i])));
                r_k_rd[i]   <= rate_s * r_j_dd[i];
            end

            for (int i = 0; i < NUM_DIR; i++) begin
                if (r_k.obst) begin
                    r_out[i*POP_W +: POP_W] <= r_k.pops[OPPOSITE[i]];
                end else begin
                    r_out[i*POP_W +: POP_W] <= sat32(40'($signed(r_k.pops[i]))
                                                     + 40'(mq(r_k_rd[i])));
                end
            end
            if (r_k.obst || !i_cfg.save) begin
                r_out[OUT_W-1 -: 3*POP_W] <= '0;
            end else begin
                r_out[OUT_W-1 -: 3*POP_W] <= {r_k.uy, r_k.ux, r_k.rho};
            end
        end
    end

endmodule

### rtl/d2q9_bgk_collide_bounce_back_unit.sv
`timescale 1ns / 1ps
// D2Q9 BGK collision with bounce-back, one lattice node per transaction.
// s_axis carries the nine populations of a node in tdata and the obstacle
// flag in tuser; m_axis returns nine post-collision populations plus the
// density and velocity moments, zeroed for an obstacle node or with saving
// off. The block takes one node every cycle while m_axis is not stalled.
// An accepted input transaction passes the front register, which loads the
// moment sums, the node queue, divider set-up, 32 restoring steps of the
// velocity divider (one quotient bit per stage for x and y in parallel) and
// 12 stages of multiplies and saturating adds for the equilibrium, the last
// of which is the output register.
// A stall on m_axis freezes the back pipeline; the 4-entry queue and the
// front register keep taking nodes until they fill, then s_axis_tready drops.
// Reset empties the pipeline and the queue and loads the configuration
// defaults: relaxation rate 1.0, force_x about 0.0001, moments saved.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data; the user must
// write it only while no node is in flight (the block does not enforce this); unknown indexes are ignored.
module d2q9_bgk_collide_bounce_back_unit #(
    parameter int FRACTION_BITS = 28
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [d2q9_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [d2q9_pkg::CFG_DW-1:0]  i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // rest_in, east_in, north_in, west_in, south_in, northeast_in,
    // northwest_in, southwest_in, southeast_in (32 bits each)
    input  logic [d2q9_pkg::IN_W-1:0]    s_axis_tdata,
    // is_obstacle
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // rest_out, east_out, north_out, west_out, south_out, northeast_out,
    // northwest_out, southwest_out, southeast_out, density, velocity_x,
    // velocity_y (32 bits each)
    output logic [d2q9_pkg::OUT_W-1:0]   m_axis_tdata
);
    import d2q9_pkg::*;

    t_cfg  r_cfg;
    t_node front_node;
    logic  front_valid;
    logic  queue_ready;
    t_node queue_node;
    logic  queue_valid;
    logic  back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate    <= RATE_RST;
            r_cfg.force_x <= FORCE_RST;
            r_cfg.save    <= SAVE_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_RATE:    r_cfg.rate    <= i_cfg_data[RATE_W-1:0];
                REG_FORCE_X: r_cfg.force_x <= i_cfg_data[FORCE_W-1:0];
                REG_SAVE:    r_cfg.save    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    d2q9_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_node        (front_node),
        .o_node_valid  (front_valid),
        .i_node_ready  (queue_ready)
    );

    d2q9_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .i_node  (front_node),
        .o_valid (queue_valid),
        .i_ready (back_ready),
        .o_node  (queue_node)
    );

    d2q9_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_node        (queue_node),
        .i_node_valid  (queue_valid),
        .o_node_ready  (back_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

### rtl/d2q9_checker.sv
`timescale 1ns / 1ps
`include "d2q9_bgk_collide_bounce_back_unit_defines.svh"
module d2q9_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_cfg_we,
    input logic [d2q9_pkg::CFG_AW-1:0]  i_cfg_addr,
    input logic [d2q9_pkg::CFG_DW-1:0]  i_cfg_data,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [d2q9_pkg::IN_W-1:0]    s_axis_tdata,
    input logic                         s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [d2q9_pkg::OUT_W-1:0]   m_axis_tdata
);
    // pipeline empties on reset
    `D2Q9_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    // front register is empty after reset so input is taken at once
    `D2Q9_ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> s_axis_tready, "input not ready after reset")
    // stalled result transaction holds
    `D2Q9_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind d2q9_bgk_collide_bounce_back_unit d2q9_checker u_checker (.*);
